[design/tuh_pkg.sv]
// Shared types, constants and helpers for the Tausworthe histogram core.
package tuh_pkg;

    localparam int WORD_W          = 31;
    localparam int LAG_W           = 7;
    localparam int LAG_SHORT       = 3;
    localparam int NEXT_LAG_POS    = 24;
    localparam int NUM_BINS        = 10;
    localparam int BIN_W           = 4;
    localparam int BIN_SPAN        = 214748364;
    localparam int COUNT_OUT_W     = 32;
    localparam int COUNT_WIDTH_DEF = 32;

    localparam logic [LAG_W-1:0] SEED_RESET = 7'd105;

    typedef enum logic
    {
        OP_GENERATE = 1'b0,
        OP_READ     = 1'b1
    } op_t;

    typedef struct packed
    {
        logic             upd;
        logic [BIN_W-1:0] bin;
    } hist_req_t;

    typedef struct packed
    {
        logic [WORD_W-1:0]      value;
        logic [BIN_W-1:0]       bin;
        logic [COUNT_OUT_W-1:0] count;
    } out_item_t;

    // lower edge of bin k
    function automatic logic [WORD_W-1:0] bin_edge(input int k);
        return WORD_W'(k * BIN_SPAN);
    endfunction

endpackage

[design/tuh_if.sv]
// Channel interfaces: seed write, input items and result items.
interface tuh_cfg_if
    import tuh_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [LAG_W-1:0] seed_bits;

    modport source (output valid, output seed_bits, input ready);
    modport sink   (input valid, input seed_bits, output ready);
endinterface

interface tuh_in_if
    import tuh_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             operation;
    logic [BIN_W-1:0] bin_select;

    modport source (output valid, output operation, output bin_select, input ready);
    modport sink   (input valid, input operation, input bin_select, output ready);
endinterface

interface tuh_out_if
    import tuh_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [WORD_W-1:0]      value;
    logic [BIN_W-1:0]       bin;
    logic [COUNT_OUT_W-1:0] count;

    modport source (output valid, output value, output bin, output count, input ready);
    modport sink   (input valid, input value, input bin, input count, output ready);
endinterface

[design/tausworthe_uniform_histogram_core.sv]
// Top level: Tausworthe word generator, bin sort, histogram and result buffer.
//
//  channel  | dir | payload                      | transfer
//  cfg      | in  | seed_bits[6:0]               | valid & ready (ready always high)
//  items    | in  | operation, bin_select[3:0]   | valid & ready
//  results  | out | value[30:0], bin[3:0], count | valid & ready
//
// One item per cycle while the result buffer has room; each result is registered.
// The word, bin and counter update come combinationally from the lag register.
// A two-entry result buffer keeps items flowing while results stall; items
// stop only when both entries are full. Reset clears counters, loads seed 105.
module tausworthe_uniform_histogram_core
    import tuh_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    tuh_cfg_if.sink    cfg,
    tuh_in_if.sink     items,
    tuh_out_if.source  results
);

    logic [LAG_W-1:0]       lag_reg;
    logic [LAG_W-1:0]       lag_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   skid_valid_reg;
    logic                   skid_valid_next;
    out_item_t              out_item_reg;
    out_item_t              skid_item_reg;
    out_item_t              new_item;
    logic [WORD_W-1:0]      word;
    logic [BIN_W-1:0]       gen_bin;
    logic                   accept;
    logic                   is_read;
    logic                   out_adv;
    hist_req_t              hreq;
    logic [COUNT_OUT_W-1:0] hcount;

    assign cfg.ready   = 1'b1;
    assign items.ready = !skid_valid_reg;
    assign accept      = items.valid && items.ready;
    assign is_read     = (op_t'(items.operation) == OP_READ);
    assign out_adv     = !out_valid_reg || results.ready;

    always_comb
    begin
        word = '0;
        word[LAG_W-1:0] = lag_reg;
        for (int j = LAG_W; j < WORD_W; j++)
        begin
            word[j] = word[j-LAG_W] ^ word[j-LAG_SHORT];
        end
        gen_bin = '0;
        for (int k = 1; k < NUM_BINS; k++)
        begin
            gen_bin = gen_bin + BIN_W'(word >= bin_edge(k));
        end
    end

    assign hreq.upd = accept && !is_read;
    assign hreq.bin = is_read ? items.bin_select : gen_bin;

    tuh_histogram #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_hist (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (hreq),
        .count (hcount)
    );

    assign new_item.value = is_read ? '0 : word;
    assign new_item.bin   = hreq.bin;
    assign new_item.count = hcount;

    always_comb
    begin
        priority if (cfg.valid)
        begin
            lag_next = cfg.seed_bits;
        end
        else if (accept && !is_read)
        begin
            lag_next = word[NEXT_LAG_POS +: LAG_W];
        end
        else
        begin
            lag_next = lag_reg;
        end

        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_adv)
        begin
            out_valid_next  = skid_valid_reg || accept;
            skid_valid_next = 1'b0;
        end
        else if (accept)
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lag_reg        <= SEED_RESET;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            lag_reg        <= lag_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_adv)
        begin
            out_item_reg <= skid_valid_reg ? skid_item_reg : new_item;
        end
        if (accept && !out_adv)
        begin
            skid_item_reg <= new_item;
        end
    end

    assign results.valid = out_valid_reg;
    assign results.value = out_item_reg.value;
    assign results.bin   = out_item_reg.bin;
    assign results.count = out_item_reg.count;

endmodule

[design/tuh_histogram.sv]
// Ten saturating bin counters with one port shared by reads and updates.
module tuh_histogram
    import tuh_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  hist_req_t              req,
    output logic [COUNT_OUT_W-1:0] count
);

    logic [COUNT_WIDTH-1:0] cnt_reg [NUM_BINS];
    logic [COUNT_WIDTH-1:0] cur;
    logic [COUNT_WIDTH-1:0] inc;

    always_comb
    begin
        if (req.bin < BIN_W'(NUM_BINS))
        begin
            cur = cnt_reg[req.bin];
        end
        else
        begin
            cur = '0;
        end
        inc = (cur == {COUNT_WIDTH{1'b1}}) ? cur : cur + COUNT_WIDTH'(1);
    end

    assign count = req.upd ? COUNT_OUT_W'(inc) : COUNT_OUT_W'(cur);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_BINS; k++)
            begin
                cnt_reg[k] <= '0;
            end
        end
        else
        begin
            for (int k = 0; k < NUM_BINS; k++)
            begin
                if (req.upd && req.bin == BIN_W'(k))
                begin
                    cnt_reg[k] <= inc;
                end
            end
        end
    end

endmodule
